/* sv/annexb_pkg.sv */
// ----------------------------------------------------------------------------
// annexb_pkg
// Shared types and constants for the Annex B start code unit splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package annexb_pkg;

  localparam int unsigned LA_DEPTH    = 4;
  localparam int unsigned MAX_RESULTS = LA_DEPTH + 1;
  localparam int unsigned QDEPTH      = 8;
  localparam int unsigned QIDX_W      = $clog2(QDEPTH);
  localparam int unsigned OCC_W       = $clog2(QDEPTH + 1);
  localparam int unsigned ACCEPT_MAX  = QDEPTH - MAX_RESULTS;
  localparam int unsigned LA_CNT_W    = $clog2(LA_DEPTH + 2);
  localparam int unsigned LEN_W       = 25;
  localparam int unsigned CFG_W       = 24;

  localparam logic [CFG_W-1:0] MAX_LEN_RESET = 24'd1048576;
  localparam logic [LEN_W-1:0] LEN_SAT       = 25'h100_0000;
  localparam logic [LEN_W-1:0] DET_MIN_LEN   = 25'd2;
  localparam logic [7:0]       SC_ZERO       = 8'h00;
  localparam logic [7:0]       SC_ONE        = 8'h01;

  typedef struct packed {
    logic       over;
    logic       last;
    logic [7:0] data;
  } res_t;

  typedef struct packed {
    logic [LA_CNT_W-1:0]          nout;
    res_t [MAX_RESULTS-1:0]       res;
  } push_t;

endpackage

`default_nettype wire

/* sv/annexb_start_code_unit_splitter_core.sv */
// ----------------------------------------------------------------------------
// annexb_start_code_unit_splitter_core
// Splits an Annex B byte stream into units, marking last byte and oversize.
// ----------------------------------------------------------------------------
// Results: a result can leave in the cycle after the item that causes it; bytes
// wait in up to four items of lookahead. Throughput: one item per cycle while
// the eight-entry result queue holds three results or fewer, so any item has
// room for its up to five; once the queue backs up, results beyond one per item
// hold intake while the queue drains to three or fewer. Reset:
// asynchronous, active low; clears lookahead, count, queue; max length 1048576.
`default_nettype none

module annexb_start_code_unit_splitter_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [7:0]                    s_axis_tdata_i,  // stream_byte
  input  wire logic                          s_axis_tlast_i,  // end_of_stream
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [7:0]                         m_axis_tdata_o,  // unit_byte
  output logic                               m_axis_tlast_o,  // unit_last
  output logic                               m_axis_tuser_o,  // unit_oversize
  input  wire logic                          cfg_we_i,
  input  wire logic [annexb_pkg::CFG_W-1:0]  cfg_wdata_i      // max_unit_length
);
  import annexb_pkg::*;

  logic [CFG_W-1:0]    max_len_q, max_len_d;
  logic                in_acc_w, out_acc_w;
  push_t               push_w;
  res_t                head_w;
  logic [OCC_W-1:0]    occ_w;
  logic [LA_CNT_W-1:0] la_cnt_w;

  assign in_acc_w  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc_w = m_axis_tvalid_o && m_axis_tready_i;
  assign max_len_d = cfg_we_i ? cfg_wdata_i : max_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else begin
      max_len_q <= max_len_d;
    end
  end

  annexb_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_acc_w),
    .byte_i    (s_axis_tdata_i),
    .eos_i     (s_axis_tlast_i),
    .max_len_i (max_len_q),
    .push_o    (push_w),
    .la_cnt_o  (la_cnt_w)
  );

  annexb_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_w),
    .pop_i  (out_acc_w),
    .head_o (head_w),
    .occ_o  (occ_w)
  );

  assign s_axis_tready_o = (occ_w <= OCC_W'(ACCEPT_MAX));
  assign m_axis_tvalid_o = (occ_w != '0);
  assign m_axis_tdata_o  = head_w.data;
  assign m_axis_tlast_o  = head_w.last;
  assign m_axis_tuser_o  = head_w.over;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_w <= OCC_W'(QDEPTH))
    else $error("result queue overflow");

  a_la_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    la_cnt_w <= LA_CNT_W'(LA_DEPTH))
    else $error("lookahead count out of range");

  a_eos_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc_w && s_axis_tlast_i) |=> (la_cnt_w == '0) && (occ_w != '0))
    else $error("end of stream did not flush lookahead");

endmodule

`default_nettype wire

/* sv/annexb_scan.sv */
// ----------------------------------------------------------------------------
// annexb_scan
// Lookahead register, start code detection and unit length tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module annexb_scan (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           accept_i,
  input  wire logic [7:0]                     byte_i,
  input  wire logic                           eos_i,
  input  wire logic [annexb_pkg::CFG_W-1:0]   max_len_i,
  output annexb_pkg::push_t                   push_o,
  output logic [annexb_pkg::LA_CNT_W-1:0]     la_cnt_o
);
  import annexb_pkg::*;

  localparam int unsigned BT_N = MAX_RESULTS + 2;

  logic [7:0]          la_q [LA_DEPTH];
  logic [7:0]          la_d [LA_DEPTH];
  logic [LA_CNT_W-1:0] la_cnt_q, la_cnt_d;
  logic [LEN_W-1:0]    len_q, len_d;

  logic [7:0]          bt [BT_N];
  logic [LA_CNT_W-1:0] n_w, drop_w, nk_w;
  logic                full_w, det_w, over1_w, over2_w;
  logic [LEN_W-1:0]    len_inc_w, base_w;
  logic [LEN_W-1:0]    max_ext_w;

  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                               input logic [LA_CNT_W-1:0] k);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {{(LEN_W + 1 - LA_CNT_W){1'b0}}, k};
    if (s > {1'b0, LEN_SAT}) begin
      return LEN_SAT;
    end
    return s[LEN_W-1:0];
  endfunction

  always_comb begin
    for (int i = 0; i < LA_DEPTH; i++) begin
      if (LA_CNT_W'(i) < la_cnt_q) begin
        bt[i] = la_q[i];
      end else if (LA_CNT_W'(i) == la_cnt_q) begin
        bt[i] = byte_i;
      end else begin
        bt[i] = '0;
      end
    end
    bt[LA_DEPTH] = (la_cnt_q == LA_CNT_W'(LA_DEPTH)) ? byte_i : '0;
    for (int i = LA_DEPTH + 1; i < BT_N; i++) begin
      bt[i] = '0;
    end

    n_w       = la_cnt_q + LA_CNT_W'(1);
    full_w    = (la_cnt_q == LA_CNT_W'(LA_DEPTH));
    det_w     = full_w && (len_q >= DET_MIN_LEN) && (bt[2] == SC_ZERO) &&
                (bt[3] == SC_ZERO) && (bt[4] == SC_ONE);
    if (!full_w) begin
      drop_w = '0;
    end else if (det_w && (bt[1] != SC_ZERO)) begin
      drop_w = LA_CNT_W'(2);
    end else begin
      drop_w = LA_CNT_W'(1);
    end
    nk_w      = n_w - drop_w;
    max_ext_w = {1'b0, max_len_i};
    len_inc_w = sat_add(len_q, LA_CNT_W'(1));
    over1_w   = sat_add(len_q, drop_w) > max_ext_w;
    if (det_w) begin
      base_w = '0;
    end else if (full_w) begin
      base_w = len_inc_w;
    end else begin
      base_w = len_q;
    end
    over2_w = sat_add(base_w, nk_w) > max_ext_w;

    // results are bt[0..drop-1] and, on end of stream, the rest as well
    push_o.nout = !accept_i ? '0 : (eos_i ? n_w : drop_w);
    for (int j = 0; j < MAX_RESULTS; j++) begin
      push_o.res[j].data = bt[j];
      push_o.res[j].last = (det_w && (LA_CNT_W'(j) == drop_w - LA_CNT_W'(1))) ||
                           (eos_i && (LA_CNT_W'(j) == n_w - LA_CNT_W'(1)));
      push_o.res[j].over = (det_w && over1_w &&
                            (LA_CNT_W'(j) == drop_w - LA_CNT_W'(1))) ||
                           (eos_i && over2_w &&
                            (LA_CNT_W'(j) == n_w - LA_CNT_W'(1)));
    end

    for (int i = 0; i < LA_DEPTH; i++) begin
      la_d[i] = la_q[i];
    end
    la_cnt_d = la_cnt_q;
    len_d    = len_q;
    if (accept_i) begin
      if (eos_i) begin
        for (int i = 0; i < LA_DEPTH; i++) begin
          la_d[i] = '0;
        end
        la_cnt_d = '0;
        len_d    = '0;
      end else begin
        for (int i = 0; i < LA_DEPTH; i++) begin
          la_d[i] = bt[LA_CNT_W'(i) + drop_w];
        end
        la_cnt_d = nk_w;
        len_d    = base_w;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LA_DEPTH; i++) begin
        la_q[i] <= '0;
      end
      la_cnt_q <= '0;
      len_q    <= '0;
    end else begin
      for (int i = 0; i < LA_DEPTH; i++) begin
        la_q[i] <= la_d[i];
      end
      la_cnt_q <= la_cnt_d;
      len_q    <= len_d;
    end
  end

  assign la_cnt_o = la_cnt_q;

endmodule

`default_nettype wire

/* sv/annexb_outq.sv */
// ----------------------------------------------------------------------------
// annexb_outq
// Result queue: takes up to five results per item, hands out one per cycle while popped.
// ----------------------------------------------------------------------------
`default_nettype none

module annexb_outq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire annexb_pkg::push_t             push_i,
  input  wire logic                          pop_i,
  output annexb_pkg::res_t                   head_o,
  output logic [annexb_pkg::OCC_W-1:0]       occ_o
);
  import annexb_pkg::*;

  res_t             q_q [QDEPTH];
  res_t             q_d [QDEPTH];
  logic [OCC_W-1:0] occ_q, occ_d;
  logic [OCC_W-1:0] base_w;
  logic [OCC_W-1:0] pop_w;

  always_comb begin
    pop_w  = {{(OCC_W - 1){1'b0}}, pop_i};
    base_w = occ_q - pop_w;
    for (int i = 0; i < QDEPTH - 1; i++) begin
      q_d[i] = pop_i ? q_q[i + 1] : q_q[i];
    end
    q_d[QDEPTH-1] = q_q[QDEPTH-1];
    for (int j = 0; j < MAX_RESULTS; j++) begin
      if (LA_CNT_W'(j) < push_i.nout) begin
        q_d[QIDX_W'(base_w + OCC_W'(j))] = push_i.res[j];
      end
    end
    occ_d = base_w + OCC_W'(push_i.nout);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  assign head_o = q_q[0];
  assign occ_o  = occ_q;

endmodule

`default_nettype wire

/* test/annexb_start_code_unit_splitter_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// annexb_start_code_unit_splitter_core_tb
// Feeds Annex B byte streams and checks every output item against a local
// unit splitter model (typed rows against their table entry): byte order, unit
// end marks and oversize flags, under random valid/ready idling and several max_unit_length settings.
// ----------------------------------------------------------------------------

module annexb_start_code_unit_splitter_core_tb;
  import annexb_pkg::*;

  localparam int unsigned LIMIT     = 200000;
  localparam int unsigned DRAIN_CYC = 8;
  localparam int unsigned PHASE_ITEMS = 25;
  localparam logic [CFG_W-1:0] LEN_CAP = 24'hFF_FFFF;

  typedef struct packed {
    logic [7:0] b;
    logic       eos;
    logic       typed;
    logic [7:0] w_data;
    logic       w_last;
    logic       w_over;
  } stim_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic [7:0]       s_axis_tdata;
  logic             s_axis_tlast;
  logic             m_axis_tready;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  logic             s_axis_tready_o;
  logic             m_axis_tvalid_o;
  logic [7:0]       m_axis_tdata_o;
  logic             m_axis_tlast_o;
  logic             m_axis_tuser_o;

  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned items_sent;
  int unsigned err_cnt;
  int unsigned cyc;

  // splitter model state
  logic [7:0]       held [LA_DEPTH];
  int unsigned      held_cnt;
  logic [CFG_W-1:0] unit_len;
  logic             len_sat;
  logic [CFG_W-1:0] max_len;
  res_t             step_q[$];
  res_t             unit_q[$];
  res_t             got_exp;

  // untyped rows are checked against the model
  stim_row_t dir_tab [27] = '{
    '{8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0},
    // three byte start code, unit ends, four byte flush
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h65, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'hAA, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h41, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    // four byte start code, leading zero moves to next unit
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h09, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h67, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    // start code too early in the unit, not split
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{8'h01, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0}
  };

  annexb_start_code_unit_splitter_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),   // stream_byte
    .s_axis_tlast_i  (s_axis_tlast),   // end_of_stream
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o), // unit_byte
    .m_axis_tlast_o  (m_axis_tlast_o), // unit_last
    .m_axis_tuser_o  (m_axis_tuser_o), // unit_oversize
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)       // max_unit_length
  );

  always #5 clk_i = ~clk_i;

  function automatic void put_unit_byte(input logic [7:0] b, input logic last);
    res_t r;
    if (unit_len == LEN_CAP) len_sat = 1'b1;
    else unit_len = unit_len + 1'b1;
    r.data = b;
    r.last = last;
    r.over = last && (len_sat || unit_len > max_len);
    step_q.push_back(r);
    if (last) begin
      unit_len = '0;
      len_sat  = 1'b0;
    end
  endfunction

  function automatic void split_byte(input logic [7:0] b, input logic eos);
    logic [7:0]  win [LA_DEPTH+1];
    int unsigned n;
    int unsigned drop;
    int unsigned i;
    n = held_cnt;
    for (i = 0; i < n; i++) win[i] = held[i];
    win[n] = b;
    n++;
    drop = 0;
    if (n == LA_DEPTH + 1) begin
      if (unit_len >= DET_MIN_LEN && win[2] == SC_ZERO && win[3] == SC_ZERO &&
          win[4] == SC_ONE) begin
        if (win[1] == SC_ZERO) begin
          put_unit_byte(win[0], 1'b1);
          drop = 1;
        end else begin
          put_unit_byte(win[0], 1'b0);
          put_unit_byte(win[1], 1'b1);
          drop = 2;
        end
      end else begin
        put_unit_byte(win[0], 1'b0);
        drop = 1;
      end
    end
    if (eos) begin
      for (i = drop; i < n; i++) put_unit_byte(win[i], i + 1 == n);
      held_cnt = 0;
      unit_len = '0;
      len_sat  = 1'b0;
    end else begin
      for (i = drop; i < n; i++) held[i-drop] = win[i];
      held_cnt = n - drop;
    end
  endfunction

  function automatic logic [CFG_W-1:0] pick_max_len();
    case ($urandom_range(0, 3))
      0:       return 24'd1;
      1:       return LEN_CAP;
      2:       return MAX_LEN_RESET;
      default: return CFG_W'($urandom_range(2, 24));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos, input logic typed,
                           input res_t want);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
    split_byte(b, eos);
    if (typed) begin
      step_q.delete();
      unit_q.push_back(want);
    end else begin
      while (step_q.size() != 0) unit_q.push_back(step_q.pop_front());
    end
  endtask

  task automatic set_max_len(input logic [CFG_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (unit_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we  <= 1'b0;
    max_len = v;
  endtask

  // mostly well-formed units, some noise rich in 00/01
  task automatic run_stream();
    logic [7:0]  bytes_q[$];
    int unsigned units;
    int unsigned plen;
    int unsigned u;
    int unsigned k;
    units = $urandom_range(1, 3);
    for (u = 0; u < units; u++) begin
      if ($urandom_range(0, 9) == 0) begin
        plen = $urandom_range(1, 8);
        for (k = 0; k < plen; k++)
          bytes_q.push_back(($urandom_range(0, 2) == 0) ? 8'($urandom) :
                            8'($urandom_range(0, 1)));
      end else begin
        if ($urandom_range(0, 1) == 1) bytes_q.push_back(SC_ZERO);
        bytes_q.push_back(SC_ZERO);
        bytes_q.push_back(SC_ZERO);
        bytes_q.push_back(SC_ONE);
        plen = $urandom_range(1, 10);
        for (k = 0; k < plen; k++)
          bytes_q.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 3)) :
                            8'($urandom_range(0, 255)));
      end
    end
    while (bytes_q.size() > 1) send_byte(bytes_q.pop_front(), 1'b0, 1'b0, '0);
    send_byte(bytes_q.pop_front(), 1'b1, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
      if (m_axis_tvalid_o && m_axis_tready) begin
        if (unit_q.size() == 0) begin
          $display("%0t: unexpected item byte=%02h last=%0b over=%0b", $time,
                   m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
          err_cnt++;
        end else begin
          got_exp = unit_q.pop_front();
          if (m_axis_tdata_o !== got_exp.data || m_axis_tlast_o !== got_exp.last ||
              m_axis_tuser_o !== got_exp.over) begin
            $display("%0t: mismatch exp byte=%02h last=%0b over=%0b got byte=%02h last=%0b over=%0b",
                     $time, got_exp.data, got_exp.last, got_exp.over,
                     m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc >= LIMIT) begin
      $display("annexb_start_code_unit_splitter_core_tb failed");
      $finish;
    end
  end

  initial begin
    int unsigned ph;
    int unsigned start_items;
    res_t        want;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    send_idle     = 28;
    recv_idle     = 50;
    items_sent    = 0;
    err_cnt       = 0;
    cyc           = 0;
    held_cnt      = 0;
    unit_len      = '0;
    len_sat       = 1'b0;
    max_len       = MAX_LEN_RESET;
    for (int i = 0; i < LA_DEPTH; i++) held[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      want = '{over: dir_tab[i].w_over, last: dir_tab[i].w_last, data: dir_tab[i].w_data};
      send_byte(dir_tab[i].b, dir_tab[i].eos, dir_tab[i].typed, want);
    end

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 28;
          recv_idle = 50;
          set_max_len(24'd1);
        end
        1: begin
          send_idle = 50;
          recv_idle = 28;
          set_max_len(LEN_CAP);
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          set_max_len(CFG_W'($urandom_range(2, 12)));
        end
      endcase
      start_items = items_sent;
      while (items_sent - start_items < PHASE_ITEMS) begin
        run_stream();
        if ($urandom_range(0, 2) == 0) set_max_len(pick_max_len());
      end
    end

    s_axis_tvalid <= 1'b0;
    while (unit_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (err_cnt == 0) $display("annexb_start_code_unit_splitter_core_tb passed");
    else $display("annexb_start_code_unit_splitter_core_tb failed");
    $finish;
  end

endmodule

/* annexb_start_code_unit_splitter_core.f */
sv/annexb_pkg.sv
sv/annexb_scan.sv
sv/annexb_outq.sv
sv/annexb_start_code_unit_splitter_core.sv
test/annexb_start_code_unit_splitter_core_tb.sv
